// File: hdl/srdf_pkg.sv
// shared constants and types for the slot ring duplicate filter
package srdf_pkg;

    localparam int unsigned SLOT_W      = 64;
    localparam int unsigned IDX_W       = 32;
    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned BIT_W       = 6;
    localparam int unsigned SUM_W       = 17;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned Q_W         = 18;
    localparam int unsigned REM_W       = 26;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MODIFY
    } t_back_state;

endpackage

// File: hdl/srdf_front.sv
// front part: accepts items, works out ring entry and bit position
module srdf_front #(
    parameter int unsigned RING_SLOTS  = 8,
    parameter int unsigned INDEX_LIMIT = 32768,
    parameter int unsigned E_W         = 83
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [srdf_pkg::SLOT_W-1:0]    i_slot,
    input  logic                           i_is_code,
    input  logic [srdf_pkg::IDX_W-1:0]     i_packet_index,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output logic [E_W-1:0]                 o_push_data
);

    localparam int unsigned WORDS = (INDEX_LIMIT + srdf_pkg::WORD_BITS - 1) / srdf_pkg::WORD_BITS;
    localparam int unsigned RW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned SW    = srdf_pkg::SUM_W;
    localparam int unsigned PW    = srdf_pkg::SUM_W + srdf_pkg::RECIP_W;
    localparam int unsigned DW    = srdf_pkg::REM_W;

    // weight of each slot byte: 256^k mod ring size
    localparam int unsigned W0 = 1 % RING_SLOTS;
    localparam int unsigned W1 = (W0 * 256) % RING_SLOTS;
    localparam int unsigned W2 = (W1 * 256) % RING_SLOTS;
    localparam int unsigned W3 = (W2 * 256) % RING_SLOTS;
    localparam int unsigned W4 = (W3 * 256) % RING_SLOTS;
    localparam int unsigned W5 = (W4 * 256) % RING_SLOTS;
    localparam int unsigned W6 = (W5 * 256) % RING_SLOTS;
    localparam int unsigned W7 = (W6 * 256) % RING_SLOTS;

    localparam longint unsigned RECIP_FULL =
        ((64'd1 << srdf_pkg::RECIP_SHIFT) + RING_SLOTS - 1) / RING_SLOTS;
    localparam logic [srdf_pkg::RECIP_W-1:0] RECIP = srdf_pkg::RECIP_W'(RECIP_FULL);

    logic                          r_s1_valid;
    logic [srdf_pkg::SLOT_W-1:0]   r_s1_slot;
    logic                          r_s1_code;
    logic                          r_s1_inr;
    logic [WW-1:0]                 r_s1_word;
    logic [srdf_pkg::BIT_W-1:0]    r_s1_bit;
    logic [SW-1:0]                 r_s1_sum;

    logic                          r_s2_valid;
    logic [srdf_pkg::SLOT_W-1:0]   r_s2_slot;
    logic                          r_s2_code;
    logic                          r_s2_inr;
    logic [WW-1:0]                 r_s2_word;
    logic [srdf_pkg::BIT_W-1:0]    r_s2_bit;
    logic [SW-1:0]                 r_s2_sum;
    logic [srdf_pkg::Q_W-1:0]      r_s2_q;

    logic [SW-1:0]                 n_s1_sum;
    logic [PW-1:0]                 w_prod;
    logic [srdf_pkg::Q_W-1:0]      n_s2_q;
    logic [DW-1:0]                 w_diff;
    logic [DW-1:0]                 w_rem;
    logic                          w_adv;
    logic                          w_s1_en;

    assign w_adv   = !r_s2_valid || i_push_ready;
    assign w_s1_en = !r_s1_valid || w_adv;
    assign o_ready = w_s1_en;

    // folded byte sum keeps the slot residue
    assign n_s1_sum = SW'(i_slot[7:0])   * SW'(W0) + SW'(i_slot[15:8])  * SW'(W1)
                    + SW'(i_slot[23:16]) * SW'(W2) + SW'(i_slot[31:24]) * SW'(W3)
                    + SW'(i_slot[39:32]) * SW'(W4) + SW'(i_slot[47:40]) * SW'(W5)
                    + SW'(i_slot[55:48]) * SW'(W6) + SW'(i_slot[63:56]) * SW'(W7);

    assign w_prod = PW'(r_s1_sum) * PW'(RECIP);
    assign n_s2_q = w_prod[srdf_pkg::RECIP_SHIFT +: srdf_pkg::Q_W];

    // quotient estimate may be one high
    assign w_diff = DW'(r_s2_sum) - DW'(r_s2_q) * DW'(RING_SLOTS);

    always_comb begin
        if (w_diff[DW-1]) begin
            w_rem = w_diff + DW'(RING_SLOTS);
        end else if (w_diff >= DW'(RING_SLOTS)) begin
            w_rem = w_diff - DW'(RING_SLOTS);
        end else begin
            w_rem = w_diff;
        end
    end

    assign o_push_valid = r_s2_valid;
    assign o_push_data  = {r_s2_slot, r_s2_code, r_s2_inr, w_rem[RW-1:0], r_s2_word, r_s2_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en && i_valid) begin
            r_s1_slot <= i_slot;
            r_s1_code <= i_is_code;
            r_s1_inr  <= (i_packet_index < srdf_pkg::IDX_W'(INDEX_LIMIT));
            r_s1_word <= i_packet_index[srdf_pkg::BIT_W +: WW];
            r_s1_bit  <= i_packet_index[srdf_pkg::BIT_W-1:0];
            r_s1_sum  <= n_s1_sum;
        end
        if (w_adv && r_s1_valid) begin
            r_s2_slot <= r_s1_slot;
            r_s2_code <= r_s1_code;
            r_s2_inr  <= r_s1_inr;
            r_s2_word <= r_s1_word;
            r_s2_bit  <= r_s1_bit;
            r_s2_sum  <= r_s1_sum;
            r_s2_q    <= n_s2_q;
        end
    end

endmodule

// File: hdl/srdf_fifo.sv
// two-entry queue between front and back parts
module srdf_fifo #(
    parameter int unsigned P_WIDTH = 83
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  logic [P_WIDTH-1:0] i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output logic [P_WIDTH-1:0] o_pop_data
);

    logic [P_WIDTH-1:0] r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: hdl/srdf_back.sv
// back part: ring tags, claim sweep and seen-bit read-modify-write
module srdf_back #(
    parameter int unsigned RING_SLOTS  = 8,
    parameter int unsigned INDEX_LIMIT = 32768,
    parameter int unsigned E_W         = 83
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  logic [E_W-1:0] i_pop_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_duplicate
);

    localparam int unsigned WORDS = (INDEX_LIMIT + srdf_pkg::WORD_BITS - 1) / srdf_pkg::WORD_BITS;
    localparam int unsigned RW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned DEPTH = RING_SLOTS * WORDS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MW    = 2 * srdf_pkg::WORD_BITS;
    localparam int unsigned HW    = srdf_pkg::WORD_BITS;

    // data bits in the low half of a word, coding bits in the high half
    logic [MW-1:0]                 r_mem [DEPTH];
    logic [MW-1:0]                 r_rd_data;

    logic [srdf_pkg::SLOT_W-1:0]   r_tags [RING_SLOTS];
    logic [RING_SLOTS-1:0]         r_tag_valid;

    srdf_pkg::t_back_state         r_state;
    srdf_pkg::t_back_state         n_state;
    logic [WW-1:0]                 r_clr_cnt;
    logic [RW-1:0]                 r_clr_ring;
    logic [AW-1:0]                 r_addr;
    logic [srdf_pkg::BIT_W-1:0]    r_bit;
    logic                          r_code;
    logic                          r_o_valid;
    logic                          r_o_dup;

    logic [srdf_pkg::SLOT_W-1:0]   h_slot;
    logic                          h_code;
    logic                          h_inr;
    logic [RW-1:0]                 h_ring;
    logic [WW-1:0]                 h_word;
    logic [srdf_pkg::BIT_W-1:0]    h_bit;

    logic                          w_hit;
    logic                          w_out_free;
    logic [AW-1:0]                 w_head_addr;
    logic [AW-1:0]                 w_clr_addr;
    logic [HW-1:0]                 w_mask;
    logic [HW-1:0]                 w_half;
    logic                          w_seen;
    logic [MW-1:0]                 w_set_data;

    logic                          w_claim;
    logic                          w_pop;
    logic                          w_rd_en;
    logic                          w_emit;
    logic                          w_emit_dup;
    logic                          w_we;
    logic [AW-1:0]                 w_wr_addr;
    logic [MW-1:0]                 w_wr_data;

    assign h_slot = i_pop_data[E_W-1 -: srdf_pkg::SLOT_W];
    assign h_code = i_pop_data[E_W-srdf_pkg::SLOT_W-1];
    assign h_inr  = i_pop_data[E_W-srdf_pkg::SLOT_W-2];
    assign h_ring = i_pop_data[srdf_pkg::BIT_W+WW +: RW];
    assign h_word = i_pop_data[srdf_pkg::BIT_W +: WW];
    assign h_bit  = i_pop_data[srdf_pkg::BIT_W-1:0];

    assign w_hit       = r_tag_valid[h_ring] && (r_tags[h_ring] == h_slot);
    assign w_out_free  = !r_o_valid || i_ready;
    assign w_head_addr = AW'(h_ring) * AW'(WORDS) + AW'(h_word);
    assign w_clr_addr  = AW'(r_clr_ring) * AW'(WORDS) + AW'(r_clr_cnt);

    assign w_mask     = HW'(1) << r_bit;
    assign w_half     = r_code ? r_rd_data[MW-1:HW] : r_rd_data[HW-1:0];
    assign w_seen     = |(w_half & w_mask);
    assign w_set_data = r_code ? {r_rd_data[MW-1:HW] | w_mask, r_rd_data[HW-1:0]}
                               : {r_rd_data[MW-1:HW], r_rd_data[HW-1:0] | w_mask};

    always_comb begin
        n_state = r_state;
        case (r_state)
            srdf_pkg::ST_IDLE: begin
                if (i_pop_valid) begin
                    if (!w_hit) begin
                        n_state = srdf_pkg::ST_CLEAR;
                    end else if (h_inr) begin
                        n_state = srdf_pkg::ST_MODIFY;
                    end
                end
            end
            srdf_pkg::ST_CLEAR: begin
                if (r_clr_cnt == WW'(WORDS - 1)) begin
                    n_state = srdf_pkg::ST_IDLE;
                end
            end
            srdf_pkg::ST_MODIFY: begin
                if (w_out_free) begin
                    n_state = srdf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_claim    = 1'b0;
        w_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_emit     = 1'b0;
        w_emit_dup = 1'b0;
        w_we       = 1'b0;
        w_wr_addr  = w_clr_addr;
        w_wr_data  = '0;
        case (r_state)
            srdf_pkg::ST_IDLE: begin
                // the item stays at the queue head until its entry is claimed
                w_claim = i_pop_valid && !w_hit;
                w_pop   = i_pop_valid && w_hit && (h_inr || w_out_free);
                w_rd_en = i_pop_valid && w_hit && h_inr;
                w_emit  = i_pop_valid && w_hit && !h_inr && w_out_free;
            end
            srdf_pkg::ST_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = w_clr_addr;
                w_wr_data = '0;
            end
            srdf_pkg::ST_MODIFY: begin
                w_emit     = w_out_free;
                w_emit_dup = w_seen;
                w_we       = w_out_free;
                w_wr_addr  = r_addr;
                w_wr_data  = w_set_data;
            end
            default: begin
                w_claim = 1'b0;
            end
        endcase
    end

    assign o_pop_ready = w_pop;
    assign o_valid     = r_o_valid;
    assign o_duplicate = r_o_dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srdf_pkg::ST_IDLE;
            r_tag_valid <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_claim) begin
                r_tag_valid[h_ring] <= 1'b1;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_tags[h_ring] <= h_slot;
            r_clr_ring     <= h_ring;
            r_clr_cnt      <= '0;
        end else if (r_state == srdf_pkg::ST_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + WW'(1);
        end
        if (w_rd_en) begin
            r_addr <= w_head_addr;
            r_bit  <= h_bit;
            r_code <= h_code;
        end
        if (w_emit) begin
            r_o_dup <= w_emit_dup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_head_addr];
        end
    end

endmodule

// File: hdl/slot_ring_duplicate_filter.sv
// top level of the slot ring duplicate filter
//
//  channel | valid    | ready    | payload
//  --------+----------+----------+------------------------------------
//  in      | i_valid  | o_ready  | i_slot, i_is_code, i_packet_index
//  out     | o_valid  | i_ready  | o_duplicate
//
// back part handles an in-range item as a pop with word read, then a test and write that waits
// for a free output, and pops an out-of-range index without touching the bitset memory
// claiming a ring entry zeroes all ceil(INDEX_LIMIT/64) words of its bitsets (512 by default)
// reset clears control and ring entry valid bits; bitset memory is cleared only on claim
// a stalled result holds the back part; the queue lets the front keep accepting until it fills
module slot_ring_duplicate_filter #(
    parameter int unsigned RING_SLOTS  = 8,
    parameter int unsigned INDEX_LIMIT = 32768
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [srdf_pkg::SLOT_W-1:0]    i_slot,
    input  logic                           i_is_code,
    input  logic [srdf_pkg::IDX_W-1:0]     i_packet_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_duplicate
);

    localparam int unsigned WORDS = (INDEX_LIMIT + srdf_pkg::WORD_BITS - 1) / srdf_pkg::WORD_BITS;
    localparam int unsigned RW    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned E_W   = srdf_pkg::SLOT_W + 2 + RW + WW + srdf_pkg::BIT_W;

    logic           w_push_valid;
    logic           w_push_ready;
    logic [E_W-1:0] w_push_data;
    logic           w_pop_valid;
    logic           w_pop_ready;
    logic [E_W-1:0] w_pop_data;

    srdf_front #(
        .RING_SLOTS  (RING_SLOTS),
        .INDEX_LIMIT (INDEX_LIMIT),
        .E_W         (E_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_slot         (i_slot),
        .i_is_code      (i_is_code),
        .i_packet_index (i_packet_index),
        .o_push_valid   (w_push_valid),
        .i_push_ready   (w_push_ready),
        .o_push_data    (w_push_data)
    );

    srdf_fifo #(
        .P_WIDTH (E_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    srdf_back #(
        .RING_SLOTS  (RING_SLOTS),
        .INDEX_LIMIT (INDEX_LIMIT),
        .E_W         (E_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_duplicate (o_duplicate)
    );

endmodule

// File: hdl/srdf_checker.sv
// port-level checks for the slot ring duplicate filter, bound to the top level
module srdf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_duplicate
);

    // result held while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_duplicate))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // no result can get through the front stages and queue this soon after reset
    a_rst_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_valid)
        else $error("result appeared too early after reset");

endmodule

bind slot_ring_duplicate_filter srdf_checker u_srdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_duplicate (o_duplicate)
);

// File: tb/tb_top.sv
// self-checking testbench for the slot ring duplicate filter
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RING_SLOTS  = 8;
    localparam int unsigned INDEX_LIMIT = 32768;
    localparam int unsigned MAX_GAP     = 16;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned HOLD_AT     = 250;
    localparam int unsigned RANDOM_ITEMS = 700;

    // keeps its own copy of the ring and the seen-bitsets and predicts each verdict
    class seen_predictor;
        logic [srdf_pkg::SLOT_W-1:0] ring_tag [RING_SLOTS];
        bit                ring_used[RING_SLOTS];
        // each claim bumps the entry generation; a mark from an older one reads as cleared
        int unsigned       ring_gen [RING_SLOTS];
        int unsigned       data_mark[int unsigned];
        int unsigned       code_mark[int unsigned];
        bit                pending_verdicts[$];
        int unsigned       packets, verdicts, dups_seen, claims, out_of_range, errors;

        function new();
            for (int r = 0; r < RING_SLOTS; r++) begin
                ring_tag[r]  = '1;
                ring_used[r] = 1'b0;
                ring_gen[r]  = 0;
            end
        endfunction

        function void accept_packet(logic [srdf_pkg::SLOT_W-1:0] slot, logic code,
                                    logic [srdf_pkg::IDX_W-1:0] idx);
            int unsigned ring;
            int unsigned key;
            bit          dup;
            ring = int'(slot % 64'(RING_SLOTS));
            dup  = 1'b0;
            packets++;
            if (!ring_used[ring] || ring_tag[ring] != slot) begin
                ring_used[ring] = 1'b1;
                ring_tag[ring]  = slot;
                ring_gen[ring]++;
                claims++;
            end
            if (idx >= INDEX_LIMIT) begin
                out_of_range++;
            end else begin
                key = ring * INDEX_LIMIT + int'(idx);
                if (code) begin
                    dup = code_mark.exists(key) && code_mark[key] == ring_gen[ring];
                    code_mark[key] = ring_gen[ring];
                end else begin
                    dup = data_mark.exists(key) && data_mark[key] == ring_gen[ring];
                    data_mark[key] = ring_gen[ring];
                end
            end
            pending_verdicts.push_back(dup);
        endfunction

        function void check_verdict(logic dup);
            bit want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: duplicate=%0b with no item pending", dup);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts++;
            if (dup !== want) begin
                $error("duplicate mismatch: expected %0b, actual %0b", want, dup);
                errors++;
            end else if (want) begin
                dups_seen++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [srdf_pkg::SLOT_W-1:0] i_slot;
    logic                        i_is_code;
    logic [srdf_pkg::IDX_W-1:0]  i_packet_index;
    logic                        o_valid;
    logic                        i_ready;
    logic                        o_duplicate;

    seen_predictor               predictor;
    bit                          hold_off;
    int unsigned                 send_calm_left;
    bit                          send_calm;
    logic [srdf_pkg::SLOT_W-1:0] active_slot[RING_SLOTS];

    slot_ring_duplicate_filter #(
        .RING_SLOTS  (RING_SLOTS),
        .INDEX_LIMIT (INDEX_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_slot         (i_slot),
        .i_is_code      (i_is_code),
        .i_packet_index (i_packet_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_duplicate    (o_duplicate)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // valid is only dropped when a gap follows, so back-to-back items keep it high
    task automatic offer_packet(input logic [srdf_pkg::SLOT_W-1:0] slot, input logic code,
                                input logic [srdf_pkg::IDX_W-1:0] idx);
        int unsigned gap;
        if (send_calm_left == 0) begin
            send_calm      = ~send_calm;
            send_calm_left = $urandom_range(10, 60);
        end
        send_calm_left--;
        gap = (send_calm || hold_off) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_slot         <= slot;
        i_is_code      <= code;
        i_packet_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        predictor.accept_packet(slot, code, idx);
    endtask

    task automatic drain_verdicts();
        int unsigned stall;
        int unsigned calm_left;
        bit          calm;
        bit          held;
        calm_left = 0;
        calm      = 1'b0;
        held      = 1'b0;
        forever begin
            if (calm_left == 0) begin
                calm      = ~calm;
                calm_left = $urandom_range(10, 60);
            end
            calm_left--;
            if (!held && predictor.verdicts == HOLD_AT) begin
                // long back-pressure so the internal queue fills and o_ready drops
                held     = 1'b1;
                hold_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            predictor.check_verdict(o_duplicate);
        end
    endtask

    task automatic run_directed();
        logic [srdf_pkg::SLOT_W-1:0] all_ones;
        all_ones = '1;
        // unused entry claimed by the all-ones slot on its first arrival
        offer_packet(all_ones, 1'b0, 5);
        offer_packet(all_ones, 1'b0, 5);
        offer_packet(all_ones, 1'b1, 5);
        // same ring, other tag: claim clears both bitsets
        offer_packet(64'd7, 1'b0, 5);
        offer_packet(all_ones, 1'b0, 5);
        offer_packet(all_ones, 1'b0, 5);
        // both kinds at the lowest and highest in-range index
        offer_packet(64'd0, 1'b0, 0);
        offer_packet(64'd0, 1'b0, 0);
        offer_packet(64'd0, 1'b1, 0);
        offer_packet(64'd0, 1'b1, 0);
        offer_packet(64'd0, 1'b0, INDEX_LIMIT - 1);
        offer_packet(64'd0, 1'b0, INDEX_LIMIT - 1);
        offer_packet(64'd0, 1'b1, INDEX_LIMIT - 1);
        // out-of-range indexes pass as new and are not recorded
        offer_packet(64'd0, 1'b0, INDEX_LIMIT);
        offer_packet(64'd0, 1'b0, INDEX_LIMIT);
        offer_packet(64'd0, 1'b1, 32'hFFFF_FFFF);
        offer_packet(64'd0, 1'b1, 32'hFFFF_FFFF);
        // out-of-range index still claims the entry
        offer_packet(64'd8, 1'b0, 32'h8000_0000);
        offer_packet(64'd0, 1'b0, 0);
        // largest slot that maps to ring 6
        offer_packet(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1);
        offer_packet(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1);
        offer_packet(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1);
    endtask

    function automatic logic [srdf_pkg::SLOT_W-1:0] fresh_slot(int unsigned ring);
        logic [srdf_pkg::SLOT_W-1:0] s;
        s = {$urandom, $urandom};
        s = s - (s % 64'(RING_SLOTS)) + 64'(ring);
        return s;
    endfunction

    task automatic run_random();
        int unsigned                 ring;
        int unsigned                 roll;
        logic [srdf_pkg::SLOT_W-1:0] slot;
        logic [srdf_pkg::IDX_W-1:0]  idx;
        for (int r = 0; r < RING_SLOTS; r++) active_slot[r] = fresh_slot(r);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            ring = $urandom_range(0, RING_SLOTS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // slot moves on: the entry is claimed for a new tag
                active_slot[ring] = fresh_slot(ring);
                slot = active_slot[ring];
            end else if (roll < 12) begin
                // stray slot evicts the live one, which later claims again
                slot = {$urandom, $urandom};
            end else begin
                slot = active_slot[ring];
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)      idx = $urandom_range(0, 31);
            else if (roll < 80) idx = $urandom_range(0, INDEX_LIMIT - 1);
            else if (roll < 88) idx = INDEX_LIMIT - 1 - $urandom_range(0, 7);
            else if (roll < 96) idx = $urandom;
            else                idx = (roll[0]) ? 32'(INDEX_LIMIT) : 32'hFFFF_FFFF;
            offer_packet(slot, 1'($urandom_range(0, 1)), idx);
        end
    endtask

    initial begin
        predictor      = new();
        hold_off       = 1'b0;
        send_calm      = 1'b1;
        send_calm_left = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_slot         <= '0;
        i_is_code      <= 1'b0;
        i_packet_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            drain_verdicts();
        join_none
        run_directed();
        run_random();
        i_valid <= 1'b0;
        while (predictor.pending_verdicts.size() != 0) @(posedge i_clk);
        // a stray extra result would show up during this wait
        repeat (40) @(posedge i_clk);
        predictor.errors += predictor.pending_verdicts.size();
        $display("covered %0d items and %0d verdicts: %0d duplicates, %0d entry claims,",
                 predictor.packets, predictor.verdicts, predictor.dups_seen,
                 predictor.claims);
        $display("%0d out-of-range indexes, one long output stall; %0d errors",
                 predictor.out_of_range, predictor.errors);
        if (predictor.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/srdf_pkg.sv
hdl/srdf_front.sv
hdl/srdf_fifo.sv
hdl/srdf_back.sv
hdl/slot_ring_duplicate_filter.sv
hdl/srdf_checker.sv
tb/tb_top.sv
